// ----- rtl/rmsh_pkg.sv -----
package rmsh_pkg;

	// cmd codes
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_ADD   = 1'b1;

	// classification of one queued transaction, produced by the front end
	typedef struct packed {
		logic clr;   // cmd 0: clear all accumulators
		logic neg;   // sample below zero
		logic zero;  // sample equal to zero
	} cls_t;

endpackage

// ----- rtl/rmsh_front.sv -----
module rmsh_front import rmsh_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	output logic                          stall,
	input  logic                          cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          pop,
	output logic                          q_valid,
	output cls_t                          q_cls,
	output logic        [SAMPLE_BITS-1:0] q_mag,
	output logic        [SAMPLE_BITS-1:0] q_sample
);

	localparam int SW = SAMPLE_BITS;

	cls_t          cls_in;
	logic [SW-1:0] mag_in;
	logic          push;

	cls_t          ent_cls_q [2];
	logic [SW-1:0] ent_mag_q [2];
	logic [SW-1:0] ent_smp_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    fill_q;

	assign cls_in.clr  = (cmd == CMD_CLEAR);
	assign cls_in.neg  = sample[SW-1];
	assign cls_in.zero = (sample == '0);
	// magnitude of the most negative code still fits as unsigned
	assign mag_in = sample[SW-1] ? (~sample + 1'b1) : sample;

	assign stall   = fill_q[1];
	assign push    = valid & ~stall;
	assign q_valid = (fill_q != 2'd0);
	assign q_cls    = ent_cls_q[rp_q];
	assign q_mag    = ent_mag_q[rp_q];
	assign q_sample = ent_smp_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_cls_q[wp_q] <= cls_in;
			ent_mag_q[wp_q] <= mag_in;
			ent_smp_q[wp_q] <= sample;
		end
	end

endmodule

// ----- rtl/rmsh_div.sv -----
module rmsh_div #(
	parameter int DW  = 80,
	parameter int DVW = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	output logic           done,
	output logic [DW-1:0]  quotient
);

	localparam int CTW = $clog2(DW);

	logic           busy_q;
	logic           done_q;
	logic [CTW-1:0] step_q;
	logic [DVW:0]   rem_q;
	logic [DW-1:0]  quo_q;
	logic [DVW-1:0] dvs_q;

	logic [DVW:0]   rem_sh;
	logic           ge;
	logic [DVW:0]   rem_n;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q[DVW-1:0], quo_q[DW-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});
	assign rem_n  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == CTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

// ----- rtl/rmsh_back.sv -----
module rmsh_back import rmsh_pkg::*; #(
	parameter int COUNT_BITS  = 24,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  cls_t                   q_cls,
	input  logic [SAMPLE_BITS-1:0] q_mag,
	input  logic [SAMPLE_BITS-1:0] q_sample,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [COUNT_BITS-1:0]  count,
	output logic [SAMPLE_BITS-1:0] mean,
	output logic [SAMPLE_BITS-1:0] std_dev,
	output logic [SAMPLE_BITS-1:0] harmonic_mean,
	output logic                   harmonic_valid,
	output logic                   overflow
);

	localparam int CW  = COUNT_BITS;
	localparam int SW  = SAMPLE_BITS;
	localparam int F   = FRAC_BITS;
	localparam int VW  = SW + CW;
	localparam int QW  = 2 * SW + CW;
	localparam int RW  = SW + F + CW;
	localparam int PW  = 2 * SW + 2 * CW;
	localparam int HW  = CW + 3 * F + 1;
	localparam int DW  = (PW > HW) ? PW : HW;
	localparam int DVW = (RW > 2 * CW) ? RW : 2 * CW;
	localparam int SCW = $clog2(SW);

	localparam logic [DW-1:0]     RCP_NUM = DW'(1) << (3 * F);
	localparam logic [SW+F-1:0]   RCP_LIM = '1;
	localparam logic [DW-1:0]     HALF    = DW'(1) << (SW - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RCP  = 4'd1;
	localparam logic [3:0] S_STAT = 4'd2;
	localparam logic [3:0] S_MEAN = 4'd3;
	localparam logic [3:0] S_MUL1 = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_MUL3 = 4'd6;
	localparam logic [3:0] S_VAR  = 4'd7;
	localparam logic [3:0] S_SQRT = 4'd8;
	localparam logic [3:0] S_HM   = 4'd9;
	localparam logic [3:0] S_HDIV = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [3:0]     st_q;
	logic [CW-1:0]  cnt_q;
	logic [VW-1:0]  vsum_q;
	logic [QW-1:0]  sq_q;
	logic [RW-1:0]  rs_q;
	logic           hok_q;
	logic           ovf_q;
	logic           rvalid_q;

	logic [VW-1:0]  mag_q;
	logic [PW-1:0]  a_q;
	logic [PW-1:0]  ma_q;
	logic [VW-1:0]  mb_q;
	logic [PW-1:0]  mp_q;
	logic [2*SW-1:0] x_q;
	logic [SW+1:0]  rem_q;
	logic [SW-1:0]  root_q;
	logic [SCW-1:0] sc_q;
	logic [SW-1:0]  mean_q;
	logic [SW-1:0]  sd_q;
	logic [SW-1:0]  hm_q;
	logic           hv_q;
	logic [CW-1:0]  count_o_q;
	logic [SW-1:0]  mean_o_q;
	logic [SW-1:0]  sd_o_q;
	logic [SW-1:0]  hm_o_q;
	logic           hv_o_q;
	logic           ovf_o_q;

	logic           div_start;
	logic [DW-1:0]  div_a;
	logic [DVW-1:0] div_b;
	logic           div_done;
	logic [DW-1:0]  div_q;

	logic           full;
	logic           rcp_go;
	logic [VW-1:0]  mag_c;
	logic           mul_done;
	logic           var_skip;
	logic           var_big;
	logic           hm_go;
	logic           out_free;
	logic [DW-1:0]  qm_sat;
	logic [SW+F-1:0] rc_sat;
	logic [SW+1:0]  rem_t;
	logic [SW+1:0]  trial;
	logic           sq_ge;
	logic [SW-1:0]  root_n;

	assign full     = (cnt_q == '1);
	assign rcp_go   = !q_cls.clr && !full && hok_q && !q_cls.neg && !q_cls.zero;
	assign mag_c    = vsum_q[VW-1] ? (~vsum_q + 1'b1) : vsum_q;
	assign mul_done = (mb_q == '0);
	assign var_skip = (vsum_q == '0) || (a_q < mp_q);
	assign var_big  = |div_q[DW-1:2*SW];
	assign hm_go    = hok_q && (rs_q != '0);
	assign out_free = !rvalid_q || !result_stall;
	assign pop      = (st_q == S_IDLE) && q_valid;

	assign qm_sat = vsum_q[VW-1] ? ((div_q > HALF) ? HALF : div_q)
	                             : ((div_q > HALF - 1'b1) ? HALF - 1'b1 : div_q);
	assign rc_sat = (div_q > DW'(RCP_LIM)) ? RCP_LIM : div_q[SW+F-1:0];

	// digit-by-digit square root, two radicand bits per step
	assign rem_t  = {rem_q[SW-1:0], x_q[2*SW-1:2*SW-2]};
	assign trial  = {root_q, 2'b01};
	assign sq_ge  = (rem_t >= trial);
	assign root_n = {root_q[SW-2:0], sq_ge};

	always_comb begin
		div_start = 1'b0;
		div_a     = '0;
		div_b     = '0;
		unique case (st_q)
			S_IDLE: begin
				if (q_valid && rcp_go) begin
					div_start = 1'b1;
					div_a     = RCP_NUM;
					div_b     = DVW'(q_mag);
				end
			end
			S_STAT: begin
				if (cnt_q != '0) begin
					div_start = 1'b1;
					div_a     = DW'(mag_c);
					div_b     = DVW'(cnt_q);
				end
			end
			S_MUL3: begin
				if (mul_done) begin
					div_start = 1'b1;
					div_a     = DW'(a_q);
					div_b     = DVW'(mp_q[2*CW-1:0]);
				end
			end
			S_HM: begin
				if (hm_go) begin
					div_start = 1'b1;
					div_a     = DW'(cnt_q) << (3 * F);
					div_b     = DVW'(rs_q);
				end
			end
			default: ;
		endcase
	end

	rmsh_div #(
		.DW  (DW),
		.DVW (DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			cnt_q    <= '0;
			vsum_q   <= '0;
			sq_q     <= '0;
			rs_q     <= '0;
			hok_q    <= 1'b1;
			ovf_q    <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			if (st_q == S_OUT && out_free)
				rvalid_q <= 1'b1;
			else if (!result_stall)
				rvalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						st_q <= S_STAT;
						if (q_cls.clr) begin
							cnt_q  <= '0;
							vsum_q <= '0;
							sq_q   <= '0;
							rs_q   <= '0;
							hok_q  <= 1'b1;
							ovf_q  <= 1'b0;
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q  <= cnt_q + 1'b1;
							vsum_q <= vsum_q + {{(VW-SW){q_sample[SW-1]}}, q_sample};
							sq_q   <= sq_q + QW'(q_mag) * QW'(q_mag);
							if (hok_q) begin
								if (q_cls.neg || q_cls.zero)
									hok_q <= 1'b0;
								else
									st_q <= S_RCP;
							end
						end
					end
				end
				S_RCP: begin
					if (div_done) begin
						rs_q <= rs_q + RW'(rc_sat);
						st_q <= S_STAT;
					end
				end
				S_STAT: st_q <= (cnt_q == '0) ? S_OUT : S_MEAN;
				S_MEAN: if (div_done) st_q <= S_MUL1;
				S_MUL1: if (mul_done) st_q <= S_MUL2;
				S_MUL2: if (mul_done) st_q <= var_skip ? S_HM : S_MUL3;
				S_MUL3: if (mul_done) st_q <= S_VAR;
				S_VAR:  if (div_done) st_q <= var_big ? S_HM : S_SQRT;
				S_SQRT: if (sc_q == SCW'(SW - 1)) st_q <= S_HM;
				S_HM:   st_q <= hm_go ? S_HDIV : S_OUT;
				S_HDIV: if (div_done) st_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// shift-add multiplier runs until the multiplier operand is used up
		if (mb_q != '0) begin
			if (mb_q[0])
				mp_q <= mp_q + ma_q;
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
		case (st_q)
			S_STAT: begin
				mag_q  <= mag_c;
				mean_q <= '0;
				sd_q   <= '0;
				hm_q   <= '0;
				hv_q   <= 1'b0;
			end
			S_MEAN: begin
				if (div_done) begin
					mean_q <= vsum_q[VW-1] ? (~qm_sat[SW-1:0] + 1'b1) : qm_sat[SW-1:0];
					ma_q   <= PW'(sq_q);
					mb_q   <= VW'(cnt_q);
					mp_q   <= '0;
				end
			end
			S_MUL1: begin
				if (mul_done) begin
					a_q  <= mp_q;
					ma_q <= PW'(mag_q);
					mb_q <= mag_q;
					mp_q <= '0;
				end
			end
			S_MUL2: begin
				if (mul_done && !var_skip) begin
					a_q  <= a_q - mp_q;
					ma_q <= PW'(cnt_q);
					mb_q <= VW'(cnt_q);
					mp_q <= '0;
				end
			end
			S_VAR: begin
				if (div_done) begin
					if (var_big)
						sd_q <= '1;
					x_q    <= div_q[2*SW-1:0];
					rem_q  <= '0;
					root_q <= '0;
					sc_q   <= '0;
				end
			end
			S_SQRT: begin
				rem_q  <= sq_ge ? (rem_t - trial) : rem_t;
				root_q <= root_n;
				x_q    <= x_q << 2;
				sc_q   <= sc_q + 1'b1;
				if (sc_q == SCW'(SW - 1))
					sd_q <= root_n;
			end
			S_HDIV: begin
				if (div_done) begin
					hm_q <= (|div_q[DW-1:SW]) ? '1 : div_q[SW-1:0];
					hv_q <= 1'b1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					count_o_q <= cnt_q;
					mean_o_q  <= mean_q;
					sd_o_q    <= sd_q;
					hm_o_q    <= hm_q;
					hv_o_q    <= hv_q;
					ovf_o_q   <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid   = rvalid_q;
	assign count          = count_o_q;
	assign mean           = mean_o_q;
	assign std_dev        = sd_o_q;
	assign harmonic_mean  = hm_o_q;
	assign harmonic_valid = hv_o_q;
	assign overflow       = ovf_o_q;

endmodule

// ----- rtl/running_mean_stdev_harmonic.sv -----
// Running mean, population standard deviation and harmonic mean of signed
// Q8.8 samples. Each transaction either clears the accumulators (cmd 0) or
// adds a sample (cmd 1) and returns one result with the statistics so far.
// A two-entry queue parts the input side from the arithmetic back end, and a
// result register parts it from the output side. The back end handles one
// transaction at a time; its time is set by a shared bit-serial divider of
// DW bits (80 at default, the larger of 2*SAMPLE_BITS+2*COUNT_BITS and
// COUNT_BITS+3*FRAC_BITS+1) that runs up to four times (reciprocal, mean,
// variance, harmonic mean), a shift-add multiplier of up to COUNT_BITS,
// SAMPLE_BITS+COUNT_BITS and COUNT_BITS steps and a SAMPLE_BITS-step square
// root. A clear skips the divider, multiplier and square root. Results
// truncate and saturate.
module running_mean_stdev_harmonic import rmsh_pkg::*; #(
	parameter int COUNT_BITS  = 24,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic                          cmd,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic        [COUNT_BITS-1:0]  count,
	output logic signed [SAMPLE_BITS-1:0] mean,
	output logic        [SAMPLE_BITS-1:0] std_dev,
	output logic        [SAMPLE_BITS-1:0] harmonic_mean,
	output logic                          harmonic_valid,
	output logic                          overflow
);

	logic                   q_valid;
	cls_t                   q_cls;
	logic [SAMPLE_BITS-1:0] q_mag;
	logic [SAMPLE_BITS-1:0] q_sample;
	logic                   pop;
	logic [SAMPLE_BITS-1:0] mean_u;

	rmsh_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (sample_valid),
		.stall    (sample_stall),
		.cmd      (cmd),
		.sample   (sample),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_cls    (q_cls),
		.q_mag    (q_mag),
		.q_sample (q_sample)
	);

	rmsh_back #(
		.COUNT_BITS  (COUNT_BITS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cls          (q_cls),
		.q_mag          (q_mag),
		.q_sample       (q_sample),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.count          (count),
		.mean           (mean_u),
		.std_dev        (std_dev),
		.harmonic_mean  (harmonic_mean),
		.harmonic_valid (harmonic_valid),
		.overflow       (overflow)
	);

	assign mean = $signed(mean_u);

	a_hv_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!harmonic_valid || count != '0))
		else $error("harmonic_valid with empty count");

	a_hm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !harmonic_valid) |-> (harmonic_mean == '0))
		else $error("harmonic_mean nonzero while invalid");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && count == '0) |-> (mean == '0 && std_dev == '0))
		else $error("statistics nonzero with empty count");

endmodule
